>>> hdl/slle_pkg.sv
// ----------------------------------------------------------------------------
// slle_pkg
// Shared types, codes and widths of the sorted linked list engine.
// ----------------------------------------------------------------------------
package slle_pkg;

    localparam int DEFAULT_SLOTS = 32;

    localparam int KEY_W      = 8;
    localparam int SLOT_W     = 5;
    localparam int STATUS_W   = 3;
    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 3;
    localparam int M_TPAD_W   = M_TDATA_W - 2 * SLOT_W - 1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    localparam int OP_W = 4;

    localparam logic [OP_W-1:0] OP_NONE          = 4'd0;
    localparam logic [OP_W-1:0] OP_START         = 4'd1;
    localparam logic [OP_W-1:0] OP_SCAN          = 4'd2;
    localparam logic [OP_W-1:0] OP_SCAN_END      = 4'd3;
    localparam logic [OP_W-1:0] OP_INS_EMPTY     = 4'd4;
    localparam logic [OP_W-1:0] OP_INS_HEAD_RD   = 4'd5;
    localparam logic [OP_W-1:0] OP_INS_NEWHEAD   = 4'd6;
    localparam logic [OP_W-1:0] OP_INS_SPL_MID   = 4'd7;
    localparam logic [OP_W-1:0] OP_INS_SPL_TAIL  = 4'd8;
    localparam logic [OP_W-1:0] OP_INS_LINK      = 4'd9;
    localparam logic [OP_W-1:0] OP_ADVANCE       = 4'd10;
    localparam logic [OP_W-1:0] OP_DEL_START     = 4'd11;
    localparam logic [OP_W-1:0] OP_DEL_FOUND     = 4'd12;
    localparam logic [OP_W-1:0] OP_REJECT        = 4'd13;
    localparam logic [OP_W-1:0] OP_EMIT          = 4'd14;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [STATUS_W-1:0] status;
    } dp_ctrl_t;

    typedef struct packed {
        logic is_delete;
        logic empty;
        logic scan_last;
        logic dup;
        logic free_found;
        logic key_lt;
        logic key_eq;
        logic tail_cur;
        logic first;
        logic out_free;
    } dp_stat_t;

endpackage

>>> hdl/sorted_linked_list_engine_core.sv
// ----------------------------------------------------------------------------
// sorted_linked_list_engine_core
// Byte keys held in ascending order as a linked list over fixed slots.
// ----------------------------------------------------------------------------
// Each input word is one command: tuser selects insert or delete and tdata
// carries the key. Each command returns exactly one output word with the
// status in tuser and the slot, head slot and non-empty flag in tdata.
// An insert reads every slot once through the key memory port to find a
// duplicate and the lowest free slot, then walks the chain one link per
// cycle. A rejected insert or one into an empty list skips the walk. A
// delete walks from the head one link per cycle. One command is in work at
// a time.
// The output word sits in a register, so the next command is accepted
// while it waits; a stalled receiver holds the block only when a second
// result is ready. Reset empties the list at once; the key and link
// memories are not cleared, and their contents count only for slots in use.
// ----------------------------------------------------------------------------
module sorted_linked_list_engine_core #(
    parameter int SLOTS = slle_pkg::DEFAULT_SLOTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Bits from the lowest up: key.
    input  logic [slle_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // Bits from the lowest up: command.
    input  logic [slle_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Bits from the lowest up: slot, head_slot, list_nonempty, zero padding.
    output logic [slle_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // Bits from the lowest up: status.
    output logic [slle_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    slle_pkg::dp_ctrl_t ctrl;
    slle_pkg::dp_stat_t stat;

    slle_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .ctrl          (ctrl)
    );

    slle_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> hdl/slle_ctrl.sv
// ----------------------------------------------------------------------------
// slle_ctrl
// Sequencer of the sorted linked list engine: scan, walk, splice and emit.
// ----------------------------------------------------------------------------
module slle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  slle_pkg::dp_stat_t stat,
    output slle_pkg::dp_ctrl_t ctrl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISP     = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_SCAN_END = 4'd3;
    localparam logic [3:0] S_IDEC     = 4'd4;
    localparam logic [3:0] S_IWALK    = 4'd5;
    localparam logic [3:0] S_ILINK    = 4'd6;
    localparam logic [3:0] S_DWALK    = 4'd7;
    localparam logic [3:0] S_RES      = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        ctrl.op     = slle_pkg::OP_NONE;
        ctrl.status = slle_pkg::ST_NOT_FOUND;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ctrl.op    = slle_pkg::OP_START;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (!stat.is_delete)
                begin
                    state_next = S_SCAN;
                end
                else if (stat.empty)
                begin
                    ctrl.op     = slle_pkg::OP_REJECT;
                    ctrl.status = slle_pkg::ST_NOT_FOUND;
                    state_next  = S_RES;
                end
                else
                begin
                    ctrl.op    = slle_pkg::OP_DEL_START;
                    state_next = S_DWALK;
                end
            end
            S_SCAN:
            begin
                ctrl.op = slle_pkg::OP_SCAN;
                if (stat.scan_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                ctrl.op    = slle_pkg::OP_SCAN_END;
                state_next = S_IDEC;
            end
            S_IDEC:
            begin
                if (stat.dup)
                begin
                    ctrl.op     = slle_pkg::OP_REJECT;
                    ctrl.status = slle_pkg::ST_DUPLICATE;
                    state_next  = S_RES;
                end
                else if (!stat.free_found)
                begin
                    ctrl.op     = slle_pkg::OP_REJECT;
                    ctrl.status = slle_pkg::ST_FULL;
                    state_next  = S_RES;
                end
                else if (stat.empty)
                begin
                    ctrl.op    = slle_pkg::OP_INS_EMPTY;
                    state_next = S_RES;
                end
                else
                begin
                    ctrl.op    = slle_pkg::OP_INS_HEAD_RD;
                    state_next = S_IWALK;
                end
            end
            S_IWALK:
            begin
                if (stat.key_lt && stat.first)
                begin
                    ctrl.op    = slle_pkg::OP_INS_NEWHEAD;
                    state_next = S_RES;
                end
                else if (stat.key_lt)
                begin
                    ctrl.op    = slle_pkg::OP_INS_SPL_MID;
                    state_next = S_ILINK;
                end
                else if (stat.tail_cur)
                begin
                    ctrl.op    = slle_pkg::OP_INS_SPL_TAIL;
                    state_next = S_ILINK;
                end
                else
                begin
                    ctrl.op = slle_pkg::OP_ADVANCE;
                end
            end
            S_ILINK:
            begin
                ctrl.op    = slle_pkg::OP_INS_LINK;
                state_next = S_RES;
            end
            S_DWALK:
            begin
                if (stat.key_eq)
                begin
                    ctrl.op    = slle_pkg::OP_DEL_FOUND;
                    state_next = S_RES;
                end
                else if (stat.tail_cur)
                begin
                    ctrl.op     = slle_pkg::OP_REJECT;
                    ctrl.status = slle_pkg::ST_NOT_FOUND;
                    state_next  = S_RES;
                end
                else
                begin
                    ctrl.op = slle_pkg::OP_ADVANCE;
                end
            end
            S_RES:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = slle_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/slle_datapath.sv
// ----------------------------------------------------------------------------
// slle_datapath
// Key and link memories, slot flags, walk registers and the result register.
// ----------------------------------------------------------------------------
module slle_datapath #(
    parameter int SLOTS = slle_pkg::DEFAULT_SLOTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  slle_pkg::dp_ctrl_t               ctrl,
    output slle_pkg::dp_stat_t               stat,
    input  logic [slle_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [slle_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [slle_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [slle_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = (IW > slle_pkg::SLOT_W) ? IW : slle_pkg::SLOT_W;

    logic [slle_pkg::KEY_W-1:0] key_mem [SLOTS];
    logic [IW-1:0]              link_mem [SLOTS];

    logic [slle_pkg::KEY_W-1:0] key_reg, key_rd_reg;
    logic                       cmd_reg;
    logic [IW-1:0]              link_rd_reg;
    logic [IW-1:0]              rd_addr;
    logic                       key_we;
    logic                       link_we;
    logic [IW-1:0]              link_wa;
    logic [IW-1:0]              link_wd;

    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic          dup_reg, dup_next;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] free_slot_reg, free_slot_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic          first_reg, first_next;
    logic [IW-1:0] splice_reg, splice_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic [SLOTS-1:0] tail_reg, tail_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [slle_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IW-1:0] res_slot_reg, res_slot_next;

    logic                          out_valid_reg, out_valid_next;
    logic [slle_pkg::STATUS_W-1:0] out_status_reg;
    logic [slle_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [slle_pkg::SLOT_W-1:0]   out_head_reg;
    logic                          out_ne_reg;
    logic [EW-1:0]                 slot_ext;
    logic [EW-1:0]                 head_ext;
    logic                          scan_cmp;

    assign stat.is_delete  = (cmd_reg == slle_pkg::CMD_DELETE);
    assign stat.empty      = (count_reg == '0);
    assign stat.scan_last  = (idx_reg == IW'(SLOTS - 1));
    assign stat.dup        = dup_reg;
    assign stat.free_found = free_found_reg;
    assign stat.key_lt     = (key_reg < key_rd_reg);
    assign stat.key_eq     = (key_reg == key_rd_reg);
    assign stat.tail_cur   = tail_reg[cur_reg];
    assign stat.first      = first_reg;
    assign stat.out_free   = !out_valid_reg || m_axis_tready;

    assign scan_cmp = ((ctrl.op == slle_pkg::OP_SCAN) || (ctrl.op == slle_pkg::OP_SCAN_END))
                      && cmp_valid_reg;

    always_comb
    begin
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        first_next      = first_reg;
        splice_next     = splice_reg;
        used_next       = used_reg;
        tail_next       = tail_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        rd_addr         = cur_reg;
        key_we          = 1'b0;
        link_we         = 1'b0;
        link_wa         = free_slot_reg;
        link_wd         = cur_reg;

        if (scan_cmp)
        begin
            if (used_reg[cmp_idx_reg])
            begin
                if (key_rd_reg == key_reg)
                begin
                    dup_next = 1'b1;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_next = 1'b1;
                free_slot_next  = cmp_idx_reg;
            end
        end

        unique case (ctrl.op)
            slle_pkg::OP_NONE:
            begin
            end
            slle_pkg::OP_START:
            begin
                idx_next        = '0;
                cmp_valid_next  = 1'b0;
                dup_next        = 1'b0;
                free_found_next = 1'b0;
            end
            slle_pkg::OP_SCAN:
            begin
                rd_addr        = idx_reg;
                cmp_idx_next   = idx_reg;
                cmp_valid_next = 1'b1;
                idx_next       = idx_reg + 1'b1;
            end
            slle_pkg::OP_SCAN_END:
            begin
                cmp_valid_next = 1'b0;
            end
            slle_pkg::OP_INS_EMPTY:
            begin
                key_we                   = 1'b1;
                link_we                  = 1'b1;
                link_wd                  = '0;
                used_next[free_slot_reg] = 1'b1;
                tail_next[free_slot_reg] = 1'b1;
                head_next                = free_slot_reg;
                count_next               = count_reg + 1'b1;
                res_status_next          = slle_pkg::ST_INSERTED;
                res_slot_next            = free_slot_reg;
            end
            slle_pkg::OP_INS_HEAD_RD:
            begin
                key_we                   = 1'b1;
                used_next[free_slot_reg] = 1'b1;
                count_next               = count_reg + 1'b1;
                rd_addr                  = head_reg;
                cur_next                 = head_reg;
                first_next               = 1'b1;
            end
            slle_pkg::OP_INS_NEWHEAD:
            begin
                link_we                  = 1'b1;
                tail_next[free_slot_reg] = 1'b0;
                head_next                = free_slot_reg;
                res_status_next          = slle_pkg::ST_INSERTED;
                res_slot_next            = free_slot_reg;
            end
            slle_pkg::OP_INS_SPL_MID:
            begin
                link_we                  = 1'b1;
                tail_next[free_slot_reg] = 1'b0;
                tail_next[prev_reg]      = 1'b0;
                splice_next              = prev_reg;
            end
            slle_pkg::OP_INS_SPL_TAIL:
            begin
                link_we                  = 1'b1;
                link_wd                  = link_rd_reg;
                tail_next[cur_reg]       = 1'b0;
                tail_next[free_slot_reg] = 1'b1;
                splice_next              = cur_reg;
            end
            slle_pkg::OP_INS_LINK:
            begin
                link_we         = 1'b1;
                link_wa         = splice_reg;
                link_wd         = free_slot_reg;
                res_status_next = slle_pkg::ST_INSERTED;
                res_slot_next   = free_slot_reg;
            end
            slle_pkg::OP_ADVANCE:
            begin
                prev_next  = cur_reg;
                cur_next   = link_rd_reg;
                rd_addr    = link_rd_reg;
                first_next = 1'b0;
            end
            slle_pkg::OP_DEL_START:
            begin
                rd_addr    = head_reg;
                cur_next   = head_reg;
                first_next = 1'b1;
            end
            slle_pkg::OP_DEL_FOUND:
            begin
                used_next[cur_reg] = 1'b0;
                count_next         = count_reg - 1'b1;
                if (first_reg)
                begin
                    head_next = tail_reg[cur_reg] ? '0 : link_rd_reg;
                end
                else
                begin
                    link_we             = 1'b1;
                    link_wa             = prev_reg;
                    link_wd             = link_rd_reg;
                    tail_next[prev_reg] = tail_reg[cur_reg];
                end
                tail_next[cur_reg] = 1'b0;
                if (count_reg == CW'(1))
                begin
                    head_next = '0;
                end
                res_status_next = slle_pkg::ST_DELETED;
                res_slot_next   = cur_reg;
            end
            slle_pkg::OP_REJECT:
            begin
                res_status_next = ctrl.status;
                res_slot_next   = '0;
            end
            slle_pkg::OP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign slot_ext = EW'(res_slot_reg);
    assign head_ext = EW'(head_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.op == slle_pkg::OP_EMIT)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[free_slot_reg] <= key_reg;
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        link_rd_reg <= link_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == slle_pkg::OP_START)
        begin
            key_reg <= s_axis_tdata[slle_pkg::KEY_W-1:0];
            cmd_reg <= s_axis_tuser[0];
        end
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        dup_reg        <= dup_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        first_reg      <= first_next;
        splice_reg     <= splice_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (ctrl.op == slle_pkg::OP_EMIT)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= slot_ext[slle_pkg::SLOT_W-1:0];
            out_head_reg   <= (count_reg != '0) ? head_ext[slle_pkg::SLOT_W-1:0] : '0;
            out_ne_reg     <= (count_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
            used_reg      <= '0;
            tail_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmp_valid_next;
            used_reg      <= used_next;
            tail_reg      <= tail_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{slle_pkg::M_TPAD_W{1'b0}}, out_ne_reg, out_head_reg, out_slot_reg};

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted linked list engine core.
// ----------------------------------------------------------------------------
// Insert and delete commands go in on the slave stream and each one returns
// a single status word on the master stream. A bench-side copy of the slot
// arrays, links, tail marks and head pointer works out the expected words;
// typed rows of a short table give theirs. The table covers the empty list,
// the extreme keys, duplicates, head, middle and tail splices and an emptied
// list. Random phases then fill the table past full, drain it past empty and
// mix both, with random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slle_pkg::*;

    localparam int NUM_SLOTS    = DEFAULT_SLOTS;
    localparam int RANDOM_WORDS = 700;
    localparam int MIX_WORDS    = 40;
    localparam int SETTLE_LEN   = 4 * NUM_SLOTS;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [SLOT_W-1:0]   head_slot;
        logic                list_nonempty;
    } list_result_t;

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic             typed;
        list_result_t     want;
    } step_row_t;

    typedef enum logic [1:0] {
        PH_FILL,
        PH_MIX,
        PH_DRAIN
    } phase_e;

    localparam int DIRECTED_LEN = 23;

    localparam step_row_t DIRECTED [DIRECTED_LEN] = '{
        '{CMD_DELETE, 8'h05, 1'b1, '{ST_NOT_FOUND, 5'd0, 5'd0, 1'b0}},
        '{CMD_INSERT, 8'h80, 1'b1, '{ST_INSERTED,  5'd0, 5'd0, 1'b1}},
        '{CMD_INSERT, 8'h80, 1'b1, '{ST_DUPLICATE, 5'd0, 5'd0, 1'b1}},
        '{CMD_INSERT, 8'h00, 1'b1, '{ST_INSERTED,  5'd1, 5'd1, 1'b1}},
        '{CMD_INSERT, 8'hFF, 1'b1, '{ST_INSERTED,  5'd2, 5'd1, 1'b1}},
        '{CMD_INSERT, 8'h40, 1'b0, '0},
        '{CMD_DELETE, 8'h41, 1'b0, '0},
        '{CMD_DELETE, 8'hFF, 1'b0, '0},
        '{CMD_DELETE, 8'h00, 1'b0, '0},
        '{CMD_INSERT, 8'hFF, 1'b0, '0},
        '{CMD_INSERT, 8'h7F, 1'b0, '0},
        '{CMD_DELETE, 8'h40, 1'b0, '0},
        '{CMD_DELETE, 8'h7F, 1'b0, '0},
        '{CMD_DELETE, 8'h80, 1'b0, '0},
        '{CMD_DELETE, 8'hFF, 1'b1, '{ST_DELETED,   5'd1, 5'd0, 1'b0}},
        '{CMD_DELETE, 8'h80, 1'b1, '{ST_NOT_FOUND, 5'd0, 5'd0, 1'b0}},
        '{CMD_INSERT, 8'hFF, 1'b1, '{ST_INSERTED,  5'd0, 5'd0, 1'b1}},
        '{CMD_INSERT, 8'h00, 1'b1, '{ST_INSERTED,  5'd1, 5'd1, 1'b1}},
        '{CMD_DELETE, 8'h01, 1'b0, '0},
        '{CMD_INSERT, 8'h01, 1'b0, '0},
        '{CMD_DELETE, 8'h00, 1'b0, '0},
        '{CMD_DELETE, 8'hFF, 1'b0, '0},
        '{CMD_DELETE, 8'h01, 1'b0, '0}
    };

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    logic [KEY_W-1:0]     key_at  [NUM_SLOTS];
    logic [SLOT_W-1:0]    link_at [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_busy  = '0;
    logic [NUM_SLOTS-1:0] last_marks = '0;
    logic [SLOT_W-1:0]    first_slot = '0;

    list_result_t pending_results [$];
    int           mismatches = 0;
    bit           calm       = 1'b0;

    sorted_linked_list_engine_core #(
        .SLOTS(NUM_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic list_result_t apply_command(input logic cmd,
                                                   input logic [KEY_W-1:0] key);
        list_result_t res;
        int           i;
        int           free_slot;
        int           prev;
        int           cur;
        bit           dup;
        bit           found;
        res = '0;
        if (cmd == CMD_INSERT)
        begin
            dup = 1'b0;
            free_slot = -1;
            for (i = 0; i < NUM_SLOTS; i++)
            begin
                if (slot_busy[i] && key_at[i] == key)
                    dup = 1'b1;
                else if (!slot_busy[i] && free_slot < 0)
                    free_slot = i;
            end
            if (dup)
                res.status = ST_DUPLICATE;
            else if (free_slot < 0)
                res.status = ST_FULL;
            else
            begin
                res.status = ST_INSERTED;
                res.slot = SLOT_W'(free_slot);
                if (slot_busy == '0)
                begin
                    first_slot = SLOT_W'(free_slot);
                    link_at[free_slot] = '0;
                    last_marks[free_slot] = 1'b1;
                end
                else if (key < key_at[first_slot])
                begin
                    link_at[free_slot] = first_slot;
                    last_marks[free_slot] = 1'b0;
                    first_slot = SLOT_W'(free_slot);
                end
                else
                begin
                    prev = first_slot;
                    for (i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (last_marks[prev])
                            break;
                        cur = link_at[prev];
                        if (key < key_at[cur])
                            break;
                        prev = cur;
                    end
                    link_at[free_slot] = link_at[prev];
                    last_marks[free_slot] = last_marks[prev];
                    link_at[prev] = SLOT_W'(free_slot);
                    last_marks[prev] = 1'b0;
                end
                key_at[free_slot] = key;
                slot_busy[free_slot] = 1'b1;
            end
        end
        else
        begin
            res.status = ST_NOT_FOUND;
            found = 1'b0;
            prev = -1;
            cur = first_slot;
            if (slot_busy != '0)
            begin
                for (i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_busy[cur] && key_at[cur] == key)
                    begin
                        found = 1'b1;
                        break;
                    end
                    if (last_marks[cur])
                        break;
                    prev = cur;
                    cur = link_at[cur];
                end
            end
            if (found)
            begin
                res.status = ST_DELETED;
                res.slot = SLOT_W'(cur);
                slot_busy[cur] = 1'b0;
                if (prev < 0)
                    first_slot = last_marks[cur] ? '0 : link_at[cur];
                else
                begin
                    link_at[prev] = link_at[cur];
                    last_marks[prev] = last_marks[cur];
                end
                last_marks[cur] = 1'b0;
                if (slot_busy == '0)
                    first_slot = '0;
            end
        end
        res.list_nonempty = |slot_busy;
        res.head_slot = res.list_nonempty ? first_slot : '0;
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] stored_key();
        int start;
        int i;
        int idx;
        start = $urandom_range(0, NUM_SLOTS - 1);
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            idx = (start + i) % NUM_SLOTS;
            if (slot_busy[idx])
                return key_at[idx];
        end
        return KEY_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [KEY_W-1:0] absent_key();
        logic [KEY_W-1:0] k;
        bit               clash;
        int               i;
        do
        begin
            k = KEY_W'($urandom_range(0, 255));
            clash = 1'b0;
            for (i = 0; i < NUM_SLOTS; i++)
                if (slot_busy[i] && key_at[i] == k)
                    clash = 1'b1;
        end
        while (clash);
        return k;
    endfunction

    task automatic issue_command(input logic cmd, input logic [KEY_W-1:0] key,
                                 input logic typed, input list_result_t want);
        int           gap;
        list_result_t predicted;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= key;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = apply_command(cmd, key);
        pending_results.push_back(typed ? want : predicted);
    endtask

    initial
    begin : stimulus
        int               row;
        int               sent;
        int               phase_no;
        int               extra;
        phase_e           kind;
        logic             cmd;
        logic [KEY_W-1:0] key;
        sent = 0;
        phase_no = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (row = 0; row < DIRECTED_LEN; row++)
            issue_command(DIRECTED[row].cmd, DIRECTED[row].key,
                          DIRECTED[row].typed, DIRECTED[row].want);
        while (sent < RANDOM_WORDS)
        begin
            case (phase_no % 4)
                0:       kind = PH_FILL;
                2:       kind = PH_DRAIN;
                default: kind = PH_MIX;
            endcase
            calm = ($urandom_range(0, 3) == 0);
            extra = 0;
            case (kind)
                PH_FILL:
                begin
                    while (extra < 3)
                    begin
                        if ($countones(slot_busy) == NUM_SLOTS)
                            extra++;
                        key = ($urandom_range(0, 9) == 0) ? stored_key() : absent_key();
                        issue_command(CMD_INSERT, key, 1'b0, '0);
                        sent++;
                    end
                end
                PH_DRAIN:
                begin
                    while (extra < 2)
                    begin
                        if (slot_busy == '0)
                            extra++;
                        key = ($urandom_range(0, 5) == 0) ? absent_key() : stored_key();
                        issue_command(CMD_DELETE, key, 1'b0, '0);
                        sent++;
                    end
                end
                default:
                begin
                    repeat (MIX_WORDS)
                    begin
                        cmd = $urandom_range(0, 1) ? CMD_DELETE : CMD_INSERT;
                        case ($urandom_range(0, 2))
                            0:       key = KEY_W'($urandom_range(0, 255));
                            1:       key = absent_key();
                            default: key = stored_key();
                        endcase
                        issue_command(cmd, key, 1'b0, '0);
                        sent++;
                    end
                end
            endcase
            phase_no++;
        end
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_LEN) @(posedge clk);
        if (mismatches == 0)
            $display("sorted_linked_list_engine_core: match");
        else
            $display("sorted_linked_list_engine_core: mismatch");
        $finish;
    end

    initial
    begin : result_check
        int           stall;
        list_result_t got;
        list_result_t want;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got.status        = m_axis_tuser;
            got.slot          = m_axis_tdata[SLOT_W-1:0];
            got.head_slot     = m_axis_tdata[2*SLOT_W-1:SLOT_W];
            got.list_nonempty = m_axis_tdata[2*SLOT_W];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got status %0d slot %0d",
                         $time, got.status, got.slot);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    mismatches++;
                if (got.status !== want.status)
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, got.status);
                if (got.slot !== want.slot)
                    $display("%0t: slot expected %0d, got %0d",
                             $time, want.slot, got.slot);
                if (got.head_slot !== want.head_slot)
                    $display("%0t: head_slot expected %0d, got %0d",
                             $time, want.head_slot, got.head_slot);
                if (got.list_nonempty !== want.list_nonempty)
                    $display("%0t: list_nonempty expected %0d, got %0d",
                             $time, want.list_nonempty, got.list_nonempty);
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("sorted_linked_list_engine_core: mismatch");
        $finish;
    end

endmodule
